// ===== sv/bqef_pkg.sv =====
// ----------------------------------------------------------------------------
// bqef_pkg: shared types and constants for the error-feedback biquad
// Sample, coefficient and output widths, register map and accumulator size.
// ----------------------------------------------------------------------------
package bqef_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int COEF_W        = 32;
  localparam int OUT_W         = 32;
  localparam int FRAC_BITS_DEF = 30;
  localparam int NUM_COEFS     = 5;

  // product of a coefficient and an output sample
  localparam int PROD_W = COEF_W + OUT_W;
  // five products plus the residue, with headroom so the sum never wraps
  localparam int ACC_W  = PROD_W + 4;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_idx_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [OUT_W-1:0]    out_t;

endpackage

// ===== sv/bqef_channels.sv =====
// ----------------------------------------------------------------------------
// bqef channels: valid/ready stream interfaces for samples in and out
// One transaction moves when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface bqef_in_if import bqef_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink   (input valid, input in_sample, output ready);
endinterface

interface bqef_out_if import bqef_pkg::*; ();
  logic valid;
  logic ready;
  out_t out_sample;

  modport source (output valid, output out_sample, input ready);
  modport sink   (input valid, input out_sample, output ready);
endinterface

// ===== sv/biquad_iir_error_feedback.sv =====
// ----------------------------------------------------------------------------
// biquad_iir_error_feedback: direct-form-I biquad with first-order error
// feedback. Q2.30 coefficients, 16-bit samples in, saturated 32-bit out.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-------------------------------
//  in_ch    | in  | valid / ready        | in_sample  signed 16
//  out_ch   | out | valid / ready        | out_sample signed 32
//  apb      | in  | psel/penable/pwrite  | paddr 5, pwdata/prdata 32
//
// One sample per clock sustained while the output is not stalled. A result
// passes through the input register, then the result register. The terms
// a1*y1 + a2*y2 are subtracted; the loop closes on the feedback registers,
// which load with the result register. Reset (rst, synchronous) clears
// history, residue, coefficients and both valid flags. A stalled output
// holds its result and the input register, then the input.
//
module biquad_iir_error_feedback
  import bqef_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  bqef_in_if.sink               in_ch,
  bqef_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int HI_W = ACC_W - FRAC_BITS - OUT_W + 1;

  // --------------------------------------------------------------------------
  // Coefficient registers
  // --------------------------------------------------------------------------
  coef_t    coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  reg_idx_t reg_idx;
  logic     cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= '0;
      coef_b1 <= '0;
      coef_b2 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_B0:  coef_b0 <= coef_t'(pwdata);
        REG_B1:  coef_b1 <= coef_t'(pwdata);
        REG_B2:  coef_b2 <= coef_t'(pwdata);
        REG_A1:  coef_a1 <= coef_t'(pwdata);
        REG_A2:  coef_a2 <= coef_t'(pwdata);
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_B0:  prdata = APB_DATA_W'(coef_b0);
      REG_B1:  prdata = APB_DATA_W'(coef_b1);
      REG_B2:  prdata = APB_DATA_W'(coef_b2);
      REG_A1:  prdata = APB_DATA_W'(coef_a1);
      REG_A2:  prdata = APB_DATA_W'(coef_a2);
      default: prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake: input register feeds the result register
  // --------------------------------------------------------------------------
  logic in_valid;     // input register holds a sample
  logic calc_fire;    // move input register into result register
  logic in_accept;

  assign calc_fire   = in_valid && (!out_ch.valid || out_ch.ready);
  assign in_ch.ready = !in_valid || calc_fire;
  assign in_accept   = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid <= 1'b1;
      end else if (calc_fire) begin
        in_valid <= 1'b0;
      end
      if (calc_fire) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input history: shift on every accepted transaction, and capture the
  // current tap set alongside the sample
  // --------------------------------------------------------------------------
  sample_t prev_in_1, prev_in_2;
  sample_t tap_x, tap_x1, tap_x2;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_in_1 <= '0;
      prev_in_2 <= '0;
    end else if (in_accept) begin
      prev_in_1 <= in_ch.in_sample;
      prev_in_2 <= prev_in_1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      tap_x  <= in_ch.in_sample;
      tap_x1 <= prev_in_1;
      tap_x2 <= prev_in_2;
    end
  end

  // --------------------------------------------------------------------------
  // Multiply-accumulate. The sum is exact: ACC_W covers five full products
  // plus the carried fraction.
  // --------------------------------------------------------------------------
  out_t                    prev_out_1, prev_out_2;
  logic [FRAC_BITS-1:0]    frac_residue;

  logic signed [PROD_W-1:0] prod_b0, prod_b1, prod_b2, prod_a1, prod_a2;
  logic signed [ACC_W-1:0]  residue_ext;
  logic signed [ACC_W-1:0]  acc;
  logic [HI_W-1:0]          acc_hi;
  logic                     acc_neg;
  logic                     acc_fits;
  out_t                     y_next;

  assign prod_b0 = PROD_W'(coef_b0) * PROD_W'(tap_x);
  assign prod_b1 = PROD_W'(coef_b1) * PROD_W'(tap_x1);
  assign prod_b2 = PROD_W'(coef_b2) * PROD_W'(tap_x2);
  assign prod_a1 = PROD_W'(coef_a1) * PROD_W'(prev_out_1);
  assign prod_a2 = PROD_W'(coef_a2) * PROD_W'(prev_out_2);

  assign residue_ext = signed'({{(ACC_W-FRAC_BITS){1'b0}}, frac_residue});

  assign acc = residue_ext
             + ACC_W'(prod_b0) + ACC_W'(prod_b1) + ACC_W'(prod_b2)
             - ACC_W'(prod_a1) - ACC_W'(prod_a2);

  // Integer part fits the output when every bit from the output sign bit
  // upward agrees; otherwise clamp toward the sign of the exact sum.
  assign acc_hi   = acc[ACC_W-1:FRAC_BITS+OUT_W-1];
  assign acc_neg  = acc[ACC_W-1];
  assign acc_fits = (acc_hi == '0) || (acc_hi == '1);

  always_comb begin
    if (acc_fits) begin
      y_next = out_t'(acc[FRAC_BITS+OUT_W-1:FRAC_BITS]);
    end else if (acc_neg) begin
      y_next = out_t'({1'b1, {(OUT_W-1){1'b0}}});
    end else begin
      y_next = out_t'({1'b0, {(OUT_W-1){1'b1}}});
    end
  end

  // --------------------------------------------------------------------------
  // Result register and feedback state; the saturated value is what feeds
  // back, while the residue keeps the low bits of the exact sum.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_out_1   <= '0;
      prev_out_2   <= '0;
      frac_residue <= '0;
    end else if (calc_fire) begin
      prev_out_1   <= y_next;
      prev_out_2   <= prev_out_1;
      frac_residue <= acc[FRAC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (calc_fire) begin
      out_ch.out_sample <= y_next;
    end
  end

endmodule
